FILE: rtl/cdec_pkg.sv
package cdec_pkg;

	// decoder mode, one-hot
	typedef enum logic [2:0] {
		MODE_PLAIN = 3'b001,
		MODE_ESC   = 3'b010,
		MODE_OCT   = 3'b100
	} mode_t;

	// decoder state carried between items
	typedef struct packed {
		mode_t      mode;
		logic [7:0] octal_value;
		logic [1:0] octal_digits;
	} dec_state_t;

	// one result item
	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       run_last;
		logic       string_end;
	} result_t;

	// everything one item decodes to
	typedef struct packed {
		logic [1:0] count;
		result_t    item0;
		result_t    item1;
		dec_state_t next_state;
	} decode_t;

	localparam dec_state_t STATE_RESET = '{mode: MODE_PLAIN, octal_value: 8'd0,
		octal_digits: 2'd0};

endpackage

FILE: rtl/cdec_decode.sv
module cdec_decode (
	input  logic [7:0]          in_byte,
	input  logic                string_last,
	input  cdec_pkg::dec_state_t state,
	output cdec_pkg::decode_t    result
);
	import cdec_pkg::*;

	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_A      = 8'h61;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6e;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_V      = 8'h76;
	localparam logic [4:0] OCT_HIGH  = 5'b00110;  // '0'..'7' share these upper bits

	logic       is_oct;
	logic [7:0] ctrl_byte;
	logic [7:0] acc_value;
	logic [1:0] digits_inc;
	logic [7:0] b0;
	logic [7:0] b1;
	logic       v0;
	logic [1:0] n;
	dec_state_t nxt;

	assign is_oct     = (in_byte[7:3] == OCT_HIGH);
	assign acc_value  = {state.octal_value[4:0], 3'b000} + {5'b00000, in_byte[2:0]};
	assign digits_inc = state.octal_digits + 2'd1;

	always_comb begin
		unique case (in_byte)
			CH_A:    ctrl_byte = 8'd7;
			CH_B:    ctrl_byte = 8'd8;
			CH_F:    ctrl_byte = 8'd12;
			CH_N:    ctrl_byte = 8'd10;
			CH_R:    ctrl_byte = 8'd13;
			CH_T:    ctrl_byte = 8'd9;
			CH_V:    ctrl_byte = 8'd11;
			default: ctrl_byte = in_byte;
		endcase
	end

	always_comb begin
		nxt = state;
		b0  = 8'd0;
		b1  = 8'd0;
		v0  = 1'b1;
		n   = 2'd0;
		unique case (state.mode)
			MODE_ESC: begin
				if (is_oct) begin
					nxt.mode         = MODE_OCT;
					nxt.octal_value  = {5'b00000, in_byte[2:0]};
					nxt.octal_digits = 2'd1;
				end else begin
					b0  = ctrl_byte;
					n   = 2'd1;
					nxt = STATE_RESET;
				end
			end
			MODE_OCT: begin
				if (is_oct) begin
					nxt.octal_value  = acc_value;
					nxt.octal_digits = digits_inc;
					// third digit closes the run
					if (digits_inc == 2'd3) begin
						b0  = acc_value;
						n   = 2'd1;
						nxt = STATE_RESET;
					end
				end else begin
					// flush the pending value, then treat the byte as plain
					b0  = state.octal_value;
					n   = 2'd1;
					nxt = STATE_RESET;
					if (in_byte == CH_BSLASH) begin
						nxt.mode = MODE_ESC;
					end else begin
						b1 = in_byte;
						n  = 2'd2;
					end
				end
			end
			default: begin
				nxt = STATE_RESET;
				if (in_byte == CH_BSLASH) begin
					nxt.mode = MODE_ESC;
				end else begin
					b0 = in_byte;
					n  = 2'd1;
				end
			end
		endcase

		if (string_last) begin
			// pending octal run at the end is flushed (no result yet in that case)
			if (nxt.mode == MODE_OCT) begin
				b0 = nxt.octal_value;
				n  = 2'd1;
			end
			nxt = STATE_RESET;
			// nothing produced: a lone end marker
			if (n == 2'd0) begin
				b0 = 8'd0;
				v0 = 1'b0;
				n  = 2'd1;
			end
		end

		result.count      = n;
		result.item0      = '{out_byte: b0, byte_valid: v0, run_last: (n == 2'd1),
			string_end: string_last && (n == 2'd1)};
		result.item1      = '{out_byte: b1, byte_valid: 1'b1, run_last: 1'b1,
			string_end: string_last};
		result.next_state = nxt;
	end

endmodule

FILE: rtl/cdec_outbuf.sv
module cdec_outbuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic [1:0]        load_count,
	input  cdec_pkg::result_t load_item0,
	input  cdec_pkg::result_t load_item1,
	output logic              can_load,
	output logic              out_valid,
	input  logic              out_ready,
	output cdec_pkg::result_t out_item
);
	import cdec_pkg::*;

	result_t    slot0_q;
	result_t    slot1_q;
	logic [1:0] count_q;
	logic       pop;

	assign out_valid = (count_q != 2'd0);
	assign out_item  = slot0_q;
	assign pop       = out_valid && out_ready;
	// room for a full pair once the current head leaves
	assign can_load  = (count_q == 2'd0) || ((count_q == 2'd1) && out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (load) begin
			count_q <= load_count;
		end else if (pop) begin
			count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot0_q <= load_item0;
			slot1_q <= load_item1;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

endmodule

FILE: rtl/c_escape_decoder_unit.sv
// Streaming decoder for C-style backslash escapes. Feed one source byte per
// item with string_last on the final byte of a string; each item gives zero,
// one or two decoded result items. \a \b \f \n \r \t \v map to control bytes,
// any other escaped byte stands for itself, and one to three octal digits
// give their value modulo 256. A pending octal value is flushed by a
// non-digit byte or by the end of the string; a trailing lone backslash gives
// nothing, and a last byte with no data result gives one end marker
// (byte_valid low, out_byte zero). run_last marks the last result of an
// input item, string_end the last result of a string. Throughput is one item
// per cycle while items give at most one result each and out_ready is high;
// an item that gives two results holds the input side until the two-slot
// result buffer, which drives one result per cycle while out_ready is high,
// has room. Results pass the input register, then the result buffer.
module c_escape_decoder_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       string_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       run_last,
	output logic       string_end
);
	import cdec_pkg::*;

	// input register stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// decoder state between items
	dec_state_t state_q;

	decode_t dec;
	logic    can_load;
	logic    consume;
	logic    load;
	result_t out_item;

	// an item with no result retires without touching the buffer
	assign consume  = valid_s1 && ((dec.count == 2'd0) || can_load);
	assign load     = consume && (dec.count != 2'd0);
	assign in_ready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= STATE_RESET;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (consume) begin
				valid_s1 <= 1'b0;
			end
			if (consume) begin
				state_q <= dec.next_state;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			last_s1 <= string_last;
		end
	end

	// escape decode of the registered item
	cdec_decode u_decode (
		.in_byte     (byte_s1),
		.string_last (last_s1),
		.state       (state_q),
		.result      (dec)
	);

	// result buffer, up to two items per input item
	cdec_outbuf u_outbuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.load_count (dec.count),
		.load_item0 (dec.item0),
		.load_item1 (dec.item1),
		.can_load   (can_load),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item)
	);

	assign out_byte   = out_item.out_byte;
	assign byte_valid = out_item.byte_valid;
	assign run_last   = out_item.run_last;
	assign string_end = out_item.string_end;

endmodule

FILE: rtl/cdec_checker.sv
module cdec_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] in_byte,
	input logic       string_last,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       byte_valid,
	input logic       run_last,
	input logic       string_end
);

	// stalled source item holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_byte) && $stable(string_last))
		else $error("stalled source item changed");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(byte_valid)
			&& $stable(run_last) && $stable(string_end))
		else $error("stalled result changed");

	// end marker carries zero and closes both run and string
	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> out_byte == 8'd0 && run_last && string_end)
		else $error("malformed end marker");

	// end of string is always end of run
	a_end_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && string_end |-> run_last)
		else $error("string end without run end");

	// first of a pair is always data
	a_pair_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !run_last |-> byte_valid && !string_end)
		else $error("non-final result without data");

endmodule

bind c_escape_decoder_unit cdec_checker u_checker (.*);
